FILE: design/pea_pkg.sv
package pea_pkg;

    localparam int IDX_W         = 15;
    localparam int MAX_PARTICLES = 32768;
    localparam int ADDR_W        = $clog2(MAX_PARTICLES);
    localparam int QUO_W         = 56;              // |force*dt| < 2^56
    localparam int DIV_BITS      = 2;               // quotient bits per stage
    localparam int DIV_STAGES    = QUO_W / DIV_BITS;

    typedef enum logic [2:0] {
        CFG_TIME_STEP   = 3'd0,
        CFG_GRAVITY_X   = 3'd1,
        CFG_GRAVITY_Y   = 3'd2,
        CFG_GRAVITY_Z   = 3'd3,
        CFG_WALL_DAMP   = 3'd4,
        CFG_FAR_WALL    = 3'd5,
        CFG_OUTLET_X    = 3'd6,
        CFG_OUTLET_RET  = 3'd7
    } t_cfg_idx;

    localparam logic [24:0]        RST_TIME_STEP  = 25'd50332;
    localparam logic signed [31:0] RST_GRAVITY_X  = 32'sd114085069;
    localparam logic signed [25:0] RST_WALL_DAMP  = -26'sd8388608;
    localparam logic [30:0]        RST_FAR_WALL   = 31'd10735741;
    localparam logic [30:0]        RST_OUTLET_X   = 31'd10737418;
    localparam logic [30:0]        RST_OUTLET_RET = 31'd10066330;

    // outlet window, Q8.24
    localparam logic signed [31:0] WIN_LOW    = 32'sd4194304;
    localparam logic signed [31:0] WIN_Y_HIGH = 32'sd6710886;
    localparam logic signed [31:0] WIN_Z_HIGH = 32'sd7214203;

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)       r = 32'sh7FFFFFFF;
        else if (x < -64'sd2147483648) r = 32'sh80000000;
        else                           r = x[31:0];
        return r;
    endfunction

    // divide by 2^24, truncating toward zero
    function automatic logic signed [63:0] f_trunc24(input logic signed [63:0] x);
        logic signed [63:0] t;
        t = x + (x[63] ? 64'sd16777215 : 64'sd0);
        return t >>> 24;
    endfunction

endpackage

FILE: design/particle_euler_advection_unit.sv
// Throughput one particle per cycle unless the output stalls or the clearing pass runs.
// The force/density divide is a 28-stage radix-4 restoring pipeline that sets the depth;
// the whole pipeline advances together and freezes while the output is stalled.
// Reset (synchronous, i_rst_n low) loads register defaults, empties the pipeline and
// starts a pass that zeroes the averaged-velocity memory; o_stall is high during
// that pass. Configuration writes are taken whenever i_rst_n is high.
module particle_euler_advection_unit
    import pea_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_idx,
    input  logic [31:0]             i_cfg_data,
    // particle in
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [IDX_W-1:0]        i_particle_index,
    input  logic signed [31:0]      i_pos_x,
    input  logic signed [31:0]      i_pos_y,
    input  logic signed [31:0]      i_pos_z,
    input  logic signed [31:0]      i_vel_x,
    input  logic signed [31:0]      i_vel_y,
    input  logic signed [31:0]      i_vel_z,
    input  logic signed [31:0]      i_force_x,
    input  logic signed [31:0]      i_force_y,
    input  logic signed [31:0]      i_force_z,
    input  logic [31:0]             i_density,
    // particle out
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [31:0]      o_new_pos_x,
    output logic signed [31:0]      o_new_pos_y,
    output logic signed [31:0]      o_new_pos_z,
    output logic signed [31:0]      o_new_vel_x,
    output logic signed [31:0]      o_new_vel_y,
    output logic signed [31:0]      o_new_vel_z,
    output logic signed [31:0]      o_avg_vel_x,
    output logic signed [31:0]      o_avg_vel_y,
    output logic signed [31:0]      o_avg_vel_z
);

    localparam int DS = DIV_STAGES;

    // ---------------- configuration registers ----------------
    logic [24:0]        r_ts;
    logic signed [31:0] r_grav [3];
    logic signed [25:0] r_wd;
    logic [30:0]        r_far;
    logic [30:0]        r_owx;
    logic [30:0]        r_orx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts    <= RST_TIME_STEP;
            r_grav[0] <= RST_GRAVITY_X;
            r_grav[1] <= '0;
            r_grav[2] <= '0;
            r_wd    <= RST_WALL_DAMP;
            r_far   <= RST_FAR_WALL;
            r_owx   <= RST_OUTLET_X;
            r_orx   <= RST_OUTLET_RET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TIME_STEP:  r_ts      <= i_cfg_data[24:0];
                CFG_GRAVITY_X:  r_grav[0] <= i_cfg_data;
                CFG_GRAVITY_Y:  r_grav[1] <= i_cfg_data;
                CFG_GRAVITY_Z:  r_grav[2] <= i_cfg_data;
                CFG_WALL_DAMP:  r_wd      <= i_cfg_data[25:0];
                CFG_FAR_WALL:   r_far     <= i_cfg_data[30:0];
                CFG_OUTLET_X:   r_owx     <= i_cfg_data[30:0];
                CFG_OUTLET_RET: r_orx     <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // ---------------- memory clearing pass ----------------
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(MAX_PARTICLES - 1)) r_clearing <= 1'b0;
        end
    end

    // ---------------- global advance ----------------
    logic r_out_v;
    logic en;
    logic in_take;

    assign en      = !r_out_v || !i_stall;
    assign o_stall = r_clearing || !en;
    assign in_take = i_valid && !o_stall;

    // ---------------- stage registers ----------------
    // S1: input capture
    logic                r_s1_v;
    logic [ADDR_W-1:0]   r_s1_idx;
    logic signed [31:0]  r_s1_p [3];
    logic signed [31:0]  r_s1_vel [3];
    logic signed [31:0]  r_s1_f [3];
    logic [31:0]         r_s1_dens;
    // S2: force*dt, gravity*dt
    logic                r_s2_v;
    logic [ADDR_W-1:0]   r_s2_idx;
    logic signed [31:0]  r_s2_p [3];
    logic signed [31:0]  r_s2_vel [3];
    logic signed [57:0]  r_s2_fdt [3];
    logic signed [57:0]  r_s2_gdt [3];
    logic [31:0]         r_s2_dens;
    // divider pipeline, index 0 is the load stage
    logic                r_d_v    [DS+1];
    logic [ADDR_W-1:0]   r_d_idx  [DS+1];
    logic signed [31:0]  r_d_p    [DS+1][3];
    logic signed [31:0]  r_d_vel  [DS+1][3];
    logic signed [32:0]  r_d_b    [DS+1][3];
    logic                r_d_neg  [DS+1][3];
    logic [31:0]         r_d_rem  [DS+1][3];
    logic [QUO_W-1:0]    r_d_dvd  [DS+1][3];
    logic [31:0]         r_d_dens [DS+1];
    // V1: new velocity
    logic                r_v1_v;
    logic [ADDR_W-1:0]   r_v1_idx;
    logic signed [31:0]  r_v1_p [3];
    logic signed [31:0]  r_v1_vel [3];
    // V2: vel*dt, vel*damping
    logic                r_v2_v;
    logic [ADDR_W-1:0]   r_v2_idx;
    logic signed [31:0]  r_v2_p [3];
    logic signed [31:0]  r_v2_vel [3];
    logic signed [57:0]  r_v2_pm [3];
    logic signed [57:0]  r_v2_dm [3];
    // V3: integrated position, damped velocity candidates
    logic                r_v3_v;
    logic [ADDR_W-1:0]   r_v3_idx;
    logic signed [31:0]  r_v3_p [3];
    logic signed [31:0]  r_v3_vel [3];
    logic signed [31:0]  r_v3_dv [3];
    // V4: after wall rules
    logic                r_v4_v;
    logic [ADDR_W-1:0]   r_v4_idx;
    logic signed [31:0]  r_v4_p [3];
    logic signed [31:0]  r_v4_vel [3];
    // V5: memory read data arrives
    logic                r_v5_v;
    logic [ADDR_W-1:0]   r_v5_idx;
    logic signed [31:0]  r_v5_p [3];
    logic signed [31:0]  r_v5_vel [3];
    logic [95:0]         r_rd;
    // last write, for read-after-write forwarding
    logic                r_lw_v;
    logic [ADDR_W-1:0]   r_lw_idx;
    logic [95:0]         r_lw_data;
    // output
    logic signed [31:0]  r_o_p [3];
    logic signed [31:0]  r_o_vel [3];
    logic signed [31:0]  r_o_avg [3];

    logic [95:0] mem [MAX_PARTICLES];

    function automatic logic [31+QUO_W:0] f_div_step(
        input logic [31:0]      rem_in,
        input logic [QUO_W-1:0] dvd_in,
        input logic [31:0]      d
    );
        logic [32:0]      t;
        logic [31:0]      rem;
        logic [QUO_W-1:0] dvd;
        rem = rem_in;
        dvd = dvd_in;
        for (int k = 0; k < DIV_BITS; k++) begin
            t   = {rem, dvd[QUO_W-1]};
            dvd = {dvd[QUO_W-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                t      = t - {1'b0, d};
                dvd[0] = 1'b1;
            end
            rem = t[31:0];
        end
        return {rem, dvd};
    endfunction

    // ---------------- combinational per-stage logic ----------------
    logic signed [31:0] v1_vel [3];
    logic signed [31:0] v3_p [3];
    logic signed [31:0] v3_dv [3];
    logic signed [31:0] v4_p [3];
    logic signed [31:0] v4_vel [3];
    logic signed [31:0] v5_avg [3];
    logic [95:0]        v5_old;
    logic               out_hit;

    always_comb begin
        logic signed [63:0] q;
        for (int a = 0; a < 3; a++) begin
            q = $signed({8'd0, r_d_dvd[DS][a]});
            if (r_d_neg[DS][a]) q = -q;
            v1_vel[a] = f_sat32(64'(r_d_vel[DS][a]) + q + 64'(r_d_b[DS][a]));
            v3_p[a]   = f_sat32(64'(r_v2_p[a]) + f_trunc24(64'(r_v2_pm[a])));
            v3_dv[a]  = f_sat32(f_trunc24(64'(r_v2_dm[a])));
        end
    end

    // wall rules, in order: outlet, x low, y far, y low, z far, z low
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            v4_p[a]   = r_v3_p[a];
            v4_vel[a] = r_v3_vel[a];
        end
        out_hit = ($signed({1'b0, r_v3_p[0]}) >= $signed({2'b0, r_owx}))
                  && !r_v3_p[0][31]
                  && (r_v3_p[1] > WIN_LOW) && (r_v3_p[1] < WIN_Y_HIGH)
                  && (r_v3_p[2] > WIN_LOW) && (r_v3_p[2] < WIN_Z_HIGH);
        if (out_hit) begin
            v4_vel[0] = r_v3_dv[0];
            v4_p[0]   = {1'b0, r_orx};
        end else if (r_v3_p[0][31]) begin
            v4_vel[0] = r_v3_dv[0];
            v4_p[0]   = '0;
        end
        for (int a = 1; a < 3; a++) begin
            if (!r_v3_p[a][31] && (r_v3_p[a][30:0] >= r_far)) begin
                v4_vel[a] = r_v3_dv[a];
                v4_p[a]   = {1'b0, r_far};
            end else if (r_v3_p[a][31]) begin
                v4_vel[a] = r_v3_dv[a];
                v4_p[a]   = '0;
            end
        end
    end

    // average with forwarding of the write made one advance earlier
    always_comb begin
        logic signed [32:0] s;
        v5_old = (r_lw_v && (r_lw_idx == r_v5_idx)) ? r_lw_data : r_rd;
        for (int a = 0; a < 3; a++) begin
            s = $signed({v5_old[32*a+31], v5_old[32*a +: 32]})
                + $signed({r_v5_vel[a][31], r_v5_vel[a]});
            s = s + $signed({32'd0, s[32]});
            v5_avg[a] = s[32:1];
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            for (int k = 0; k <= DS; k++) r_d_v[k] <= 1'b0;
            r_v1_v  <= 1'b0;
            r_v2_v  <= 1'b0;
            r_v3_v  <= 1'b0;
            r_v4_v  <= 1'b0;
            r_v5_v  <= 1'b0;
            r_lw_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_s1_v   <= in_take;
            r_s2_v   <= r_s1_v;
            r_d_v[0] <= r_s2_v;
            for (int k = 0; k < DS; k++) r_d_v[k+1] <= r_d_v[k];
            r_v1_v   <= r_d_v[DS];
            r_v2_v   <= r_v1_v;
            r_v3_v   <= r_v2_v;
            r_v4_v   <= r_v3_v;
            r_v5_v   <= r_v4_v;
            r_lw_v   <= r_v5_v;
            r_out_v  <= r_v5_v;
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge i_clk) begin
        logic [31+QUO_W:0]   st;
        logic signed [57:0]  mag;
        if (en) begin
            // S1
            r_s1_idx    <= i_particle_index[ADDR_W-1:0];
            r_s1_p[0]   <= i_pos_x;   r_s1_p[1]   <= i_pos_y;   r_s1_p[2]   <= i_pos_z;
            r_s1_vel[0] <= i_vel_x;   r_s1_vel[1] <= i_vel_y;   r_s1_vel[2] <= i_vel_z;
            r_s1_f[0]   <= i_force_x; r_s1_f[1]   <= i_force_y; r_s1_f[2]   <= i_force_z;
            r_s1_dens   <= (i_density == '0) ? 32'd1 : i_density;
            // S2
            r_s2_idx  <= r_s1_idx;
            r_s2_dens <= r_s1_dens;
            for (int a = 0; a < 3; a++) begin
                r_s2_p[a]   <= r_s1_p[a];
                r_s2_vel[a] <= r_s1_vel[a];
                r_s2_fdt[a] <= r_s1_f[a] * $signed({1'b0, r_ts});
                r_s2_gdt[a] <= r_grav[a] * $signed({1'b0, r_ts});
            end
            // divider load
            r_d_idx[0]  <= r_s2_idx;
            r_d_dens[0] <= r_s2_dens;
            for (int a = 0; a < 3; a++) begin
                mag = r_s2_fdt[a][57] ? -r_s2_fdt[a] : r_s2_fdt[a];
                r_d_p[0][a]   <= r_s2_p[a];
                r_d_vel[0][a] <= r_s2_vel[a];
                r_d_b[0][a]   <= 33'(f_trunc24(64'(r_s2_gdt[a])));
                r_d_neg[0][a] <= r_s2_fdt[a][57];
                r_d_rem[0][a] <= '0;
                r_d_dvd[0][a] <= mag[QUO_W-1:0];
            end
            // divider stages
            for (int k = 0; k < DS; k++) begin
                r_d_idx[k+1]  <= r_d_idx[k];
                r_d_dens[k+1] <= r_d_dens[k];
                for (int a = 0; a < 3; a++) begin
                    st = f_div_step(r_d_rem[k][a], r_d_dvd[k][a], r_d_dens[k]);
                    r_d_p[k+1][a]   <= r_d_p[k][a];
                    r_d_vel[k+1][a] <= r_d_vel[k][a];
                    r_d_b[k+1][a]   <= r_d_b[k][a];
                    r_d_neg[k+1][a] <= r_d_neg[k][a];
                    r_d_rem[k+1][a] <= st[31+QUO_W:QUO_W];
                    r_d_dvd[k+1][a] <= st[QUO_W-1:0];
                end
            end
            // V1..V5 and output
            r_v1_idx <= r_d_idx[DS];
            r_v2_idx <= r_v1_idx;
            r_v3_idx <= r_v2_idx;
            r_v4_idx <= r_v3_idx;
            r_v5_idx <= r_v4_idx;
            for (int a = 0; a < 3; a++) begin
                r_v1_p[a]   <= r_d_p[DS][a];
                r_v1_vel[a] <= v1_vel[a];
                r_v2_p[a]   <= r_v1_p[a];
                r_v2_vel[a] <= r_v1_vel[a];
                r_v2_pm[a]  <= r_v1_vel[a] * $signed({1'b0, r_ts});
                r_v2_dm[a]  <= r_v1_vel[a] * r_wd;
                r_v3_p[a]   <= v3_p[a];
                r_v3_vel[a] <= r_v2_vel[a];
                r_v3_dv[a]  <= v3_dv[a];
                r_v4_p[a]   <= v4_p[a];
                r_v4_vel[a] <= v4_vel[a];
                r_v5_p[a]   <= r_v4_p[a];
                r_v5_vel[a] <= r_v4_vel[a];
                r_o_p[a]    <= r_v5_p[a];
                r_o_vel[a]  <= r_v5_vel[a];
                r_o_avg[a]  <= v5_avg[a];
            end
            r_lw_idx  <= r_v5_idx;
            r_lw_data <= {v5_avg[2], v5_avg[1], v5_avg[0]};
        end
    end

    // ---------------- averaged velocity memory ----------------
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= '0;
        end else if (en && r_v5_v) begin
            mem[r_v5_idx] <= {v5_avg[2], v5_avg[1], v5_avg[0]};
        end
        if (en) begin
            r_rd <= mem[r_v4_idx];
        end
    end

    assign o_valid     = r_out_v;
    assign o_new_pos_x = r_o_p[0];
    assign o_new_pos_y = r_o_p[1];
    assign o_new_pos_z = r_o_p[2];
    assign o_new_vel_x = r_o_vel[0];
    assign o_new_vel_y = r_o_vel[1];
    assign o_new_vel_z = r_o_vel[2];
    assign o_avg_vel_x = r_o_avg[0];
    assign o_avg_vel_y = r_o_avg[1];
    assign o_avg_vel_z = r_o_avg[2];

endmodule

FILE: test/tb_particle_euler_advection_unit.sv
module tb_particle_euler_advection_unit;
    import pea_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE_Q24 = 64'sd16777216;
    localparam int     PHASE_ITEMS = 130;

    // one particle transaction on the input side
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [2:0][31:0]  pos;
        logic [2:0][31:0]  vel;
        logic [2:0][31:0]  frc;
        logic [31:0]       dens;
    } t_particle;

    // result fields in port order: pos xyz, vel xyz, avg xyz
    typedef logic [8:0][31:0] t_advected;

    // ------------------------------------------------------------------
    // Scoreboard: integrates each accepted particle and keeps the
    // expected results in order, plus its own averaged-velocity memory.
    // ------------------------------------------------------------------
    class advection_scoreboard;
        longint    dt, grav[3], damping, far_lim, outlet_x, outlet_ret;
        int        avg_mem[3][MAX_PARTICLES];
        t_advected expected_q[$];
        int        errors;
        int        compared;

        function new();
            dt         = RST_TIME_STEP;
            grav[0]    = RST_GRAVITY_X;
            grav[1]    = 0;
            grav[2]    = 0;
            damping    = RST_WALL_DAMP;
            far_lim    = RST_FAR_WALL;
            outlet_x   = RST_OUTLET_X;
            outlet_ret = RST_OUTLET_RET;
            errors     = 0;
            compared   = 0;
        endfunction

        function void set_cfg(t_cfg_idx r, logic [31:0] v);
            case (r)
                CFG_TIME_STEP:  dt         = longint'(v[24:0]);
                CFG_GRAVITY_X:  grav[0]    = longint'($signed(v));
                CFG_GRAVITY_Y:  grav[1]    = longint'($signed(v));
                CFG_GRAVITY_Z:  grav[2]    = longint'($signed(v));
                CFG_WALL_DAMP:  damping    = longint'($signed(v[25:0]));
                CFG_FAR_WALL:   far_lim    = longint'(v[30:0]);
                CFG_OUTLET_X:   outlet_x   = longint'(v[30:0]);
                CFG_OUTLET_RET: outlet_ret = longint'(v[30:0]);
                default: ;
            endcase
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint wall_hit(longint v);
            return clip32((v * damping) / ONE_Q24);
        endfunction

        function void note_particle(t_particle p);
            longint    vel[3], pos[3], avg;
            longint    dens;
            int        a;
            t_advected r;
            dens = (p.dens == 0) ? 64'sd1 : longint'(p.dens);
            for (a = 0; a < 3; a++) begin
                vel[a] = clip32(longint'($signed(p.vel[a]))
                              + (longint'($signed(p.frc[a])) * dt) / dens
                              + (grav[a] * dt) / ONE_Q24);
                pos[a] = clip32(longint'($signed(p.pos[a])) + (vel[a] * dt) / ONE_Q24);
            end
            // windowed outlet wall first, then the clamping walls
            if (pos[0] >= outlet_x && pos[1] > WIN_LOW && pos[1] < WIN_Y_HIGH &&
                pos[2] > WIN_LOW && pos[2] < WIN_Z_HIGH) begin
                vel[0] = wall_hit(vel[0]);
                pos[0] = outlet_ret;
            end
            if (pos[0] < 0) begin
                vel[0] = wall_hit(vel[0]);
                pos[0] = 0;
            end
            for (a = 1; a < 3; a++) begin
                if (pos[a] >= far_lim) begin
                    vel[a] = wall_hit(vel[a]);
                    pos[a] = far_lim;
                end
                if (pos[a] < 0) begin
                    vel[a] = wall_hit(vel[a]);
                    pos[a] = 0;
                end
            end
            for (a = 0; a < 3; a++) begin
                avg = (longint'(avg_mem[a][p.idx]) + vel[a]) / 2;
                avg_mem[a][p.idx] = int'(avg);
                r[a]     = pos[a][31:0];
                r[a + 3] = vel[a][31:0];
                r[a + 6] = avg[31:0];
            end
            expected_q.push_back(r);
        endfunction

        task report(string what, int field, logic [31:0] got, logic [31:0] want);
            $display("%0t mismatch: %s field %0d got %h want %h", $realtime, what, field,
                     got, want);
            errors++;
        endtask

        task check_result(t_advected got);
            t_advected want;
            if (expected_q.size() == 0) begin
                report("result with nothing pending", 0, got[0], 0);
            end else begin
                want = expected_q.pop_front();
                compared++;
                for (int f = 0; f < 9; f++)
                    if (got[f] !== want[f]) report("advected particle", f, got[f], want[f]);
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [31:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic [IDX_W-1:0]   i_particle_index;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [31:0] i_vel_x, i_vel_y, i_vel_z;
    logic signed [31:0] i_force_x, i_force_y, i_force_z;
    logic [31:0]        i_density;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_new_pos_x, o_new_pos_y, o_new_pos_z;
    logic signed [31:0] o_new_vel_x, o_new_vel_y, o_new_vel_z;
    logic signed [31:0] o_avg_vel_x, o_avg_vel_y, o_avg_vel_z;

    particle_euler_advection_unit i_dut (.*);

    advection_scoreboard sb = new();

    int send_idle_pct;   // chance per cycle that the sender holds off
    int rcv_stall_pct;   // chance per cycle that the receiver stalls
    int n_sent;
    int n_settings;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // generous watchdog, well above the slowest legal run incl. the clear pass
    initial begin
        #20000000;
        $display("tb_particle_euler_advection_unit: errors");
        $finish;
    end

    // Output side: values are sampled before the edge updates them, so a
    // transaction is o_valid high with our stall low going into this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result({o_avg_vel_z, o_avg_vel_y, o_avg_vel_x,
                             o_new_vel_z, o_new_vel_y, o_new_vel_x,
                             o_new_pos_z, o_new_pos_y, o_new_pos_x});
        i_stall <= i_rst_n && ($urandom_range(99) < rcv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_particle(t_particle p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_particle_index <= p.idx;
        i_pos_x   <= p.pos[0];   i_pos_y   <= p.pos[1];   i_pos_z   <= p.pos[2];
        i_vel_x   <= p.vel[0];   i_vel_y   <= p.vel[1];   i_vel_z   <= p.vel[2];
        i_force_x <= p.frc[0];   i_force_y <= p.frc[1];   i_force_z <= p.frc[2];
        i_density <= p.dens;
        // hold until the edge that takes the transaction
        do @(posedge i_clk); while (o_stall);
        sb.note_particle(p);
        n_sent++;
    endtask

    // Writes all eight registers back to back; only called with the block idle.
    task automatic apply_settings(logic [31:0] dt, logic [31:0] gx, logic [31:0] gy,
                                  logic [31:0] gz, logic [31:0] wd, logic [31:0] far,
                                  logic [31:0] ox, logic [31:0] oret);
        logic [31:0] vals[8];
        vals = '{dt, gx, gy, gz, wd, far, ox, oret};
        for (int r = 0; r < 8; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(r);
            i_cfg_data <= vals[r];
            @(posedge i_clk);
            sb.set_cfg(t_cfg_idx'(r), vals[r]);
        end
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Sender stops until everything in flight has come out, then idles before returning.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_particle mk(int idx, int px, int py, int pz, int vx, int vy,
                                     int vz, int fx, int fy, int fz, int unsigned dens);
        t_particle p;
        p.idx   = IDX_W'(idx);
        p.pos   = {pz, py, px};
        p.vel   = {vz, vy, vx};
        p.frc   = {fz, fy, fx};
        p.dens  = dens;
        return p;
    endfunction

    function automatic int srand(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Mostly particles inside or near the box (walls and outlet window get hit),
    // the rest raw 32-bit noise to push saturation and odd densities.
    function automatic t_particle rand_particle();
        t_particle p;
        int        kind;
        kind  = $urandom_range(9);
        p.idx = ($urandom_range(9) < 7) ? IDX_W'($urandom_range(31)) : IDX_W'($urandom);
        if (kind < 3) begin
            p.pos[0] = $urandom_range(10000000, 11500000);
            p.pos[1] = $urandom_range(4000000, 7000000);
            p.pos[2] = $urandom_range(4000000, 7500000);
        end else if (kind < 7) begin
            for (int a = 0; a < 3; a++) p.pos[a] = $urandom_range(11500000) - 500000;
        end
        if (kind < 7) begin
            for (int a = 0; a < 3; a++) begin
                p.vel[a] = srand(1 << 25);
                p.frc[a] = srand(1 << 22);
            end
            p.dens = ($urandom_range(19) == 0) ? 32'd0 : $urandom_range(1 << 16, 1 << 26);
        end else begin
            for (int a = 0; a < 3; a++) begin
                p.pos[a] = $urandom;
                p.vel[a] = $urandom;
                p.frc[a] = $urandom;
            end
            p.dens = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
        end
        return p;
    endfunction

    task automatic random_phase(int n);
        repeat (n) send_particle(rand_particle());
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= '0;
        i_cfg_data       <= '0;
        i_valid          <= 1'b0;
        i_stall          <= 1'b0;
        i_particle_index <= '0;
        i_pos_x <= '0; i_pos_y <= '0; i_pos_z <= '0;
        i_vel_x <= '0; i_vel_y <= '0; i_vel_z <= '0;
        i_force_x <= '0; i_force_y <= '0; i_force_z <= '0;
        i_density <= '0;
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        n_sent        = 0;
        n_settings    = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed set on reset defaults, no idling
        send_particle(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_particle(mk(1, 5000000, 5000000, 5000000, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF));
        // zero density with the largest force
        send_particle(mk(2, 5000000, 5000000, 5000000, 0, 0, 0,
                         32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0));
        // inside the outlet window
        send_particle(mk(3, 10800000, 5000000, 6000000, 1 << 24, 0, 0, 0, 0, 0, 1 << 16));
        // outlet x reached but y/z just outside the window
        send_particle(mk(4, 10800000, 4194304, 6000000, 1 << 24, 0, 0, 0, 0, 0, 1 << 16));
        send_particle(mk(5, 10800000, 5000000, 7214203, 1 << 24, 0, 0, 0, 0, 0, 1 << 16));
        // each clamping wall on its own
        send_particle(mk(6, -100, 5000000, 5000000, -(1 << 24), 0, 0, 0, 0, 0, 1 << 16));
        send_particle(mk(7, 5000000, 10735741, 5000000, 0, 1 << 24, 0, 0, 0, 0, 1 << 16));
        send_particle(mk(8, 5000000, -100, 5000000, 0, -(1 << 24), 0, 0, 0, 0, 1 << 16));
        send_particle(mk(9, 5000000, 5000000, 10735741, 0, 0, 1 << 24, 0, 0, 0, 1 << 16));
        send_particle(mk(10, 5000000, 5000000, -100, 0, 0, -(1 << 24), 0, 0, 0, 1 << 16));
        // saturation at both ends of the format
        send_particle(mk(11, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                         32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                         32'h7FFFFFFF, 1));
        send_particle(mk(12, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                         32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                         32'h80000000, 0));
        // same index back to back exercises the running average
        send_particle(mk(32767, 1000, 1000, 1000, 1 << 26, -(1 << 26), 12345, 0, 0, 0, 1));
        send_particle(mk(32767, 1000, 1000, 1000, -(1 << 26), 1 << 26, -12345, 0, 0, 0, 1));
        send_particle(mk(32767, 2000, 2000, 2000, 3, -3, 1, 0, 0, 0, 1 << 16));
        send_particle(mk(0, 5000000, 5000000, 5000000, 7, -7, 9, -5, 5, 0, 3));
        drain();

        // explicit defaults, plain random traffic
        apply_settings(50332, 114085069, 0, 0, -8388608, 10735741, 10737418, 10066330);
        random_phase(PHASE_ITEMS);
        drain();

        // step and damping of 1.0, outlet at zero
        send_idle_pct = 87;
        apply_settings(16777216, 32'h7FFFFFFF, 32'h80000000, 0, 16777216, 32'h7FFFFFFF,
                       0, 32'h7FFFFFFF);
        random_phase(PHASE_ITEMS);
        drain();

        // smallest step, opposite extremes
        send_idle_pct = 0;
        rcv_stall_pct = 87;
        apply_settings(1, 32'h80000000, 0, 32'h7FFFFFFF, -16777216, 0, 32'h7FFFFFFF, 0);
        random_phase(PHASE_ITEMS);
        drain();

        // random settings, light idling on both sides
        send_idle_pct = 12;
        rcv_stall_pct = 12;
        apply_settings($urandom_range(1, 1 << 24), $urandom, $urandom, $urandom,
                       srand(1 << 24), $urandom_range(0, 32'h7FFFFFFF),
                       $urandom_range(0, 32'h7FFFFFFF), $urandom_range(0, 32'h7FFFFFFF));
        random_phase(PHASE_ITEMS);
        drain();

        // near-default world with a random step, full rate
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        apply_settings($urandom_range(1, 200000), 114085069, srand(1 << 26), srand(1 << 26),
                       srand(1 << 24), 10735741, 10737418, 10066330);
        random_phase(PHASE_ITEMS);
        drain();

        // random settings again, slow sender and slow receiver
        send_idle_pct = 87;
        rcv_stall_pct = 87;
        apply_settings($urandom_range(1, 1 << 24), $urandom, $urandom, $urandom,
                       srand(1 << 24), $urandom_range(8000000, 12000000),
                       $urandom_range(9000000, 12000000), $urandom_range(0, 12000000));
        random_phase(PHASE_ITEMS);
        drain();

        $display("covered %0d particles over %0d register settings, %0d results compared",
                 n_sent, n_settings, sb.compared);
        $display("idling phases: none, slow sender, slow receiver, both light and heavy");
        if (sb.errors == 0) begin
            $display("tb_particle_euler_advection_unit: clean");
        end else begin
            $display("tb_particle_euler_advection_unit: errors");
        end
        $finish;
    end

endmodule
